>>> rtl/core/bfsa_pkg.sv
package bfsa_pkg;

	// Field widths of the request and grant words.
	localparam int CMD_W        = 2;
	localparam int IDX_FIELD_W  = 10;
	localparam int SIZE_FIELD_W = 16;

	// Default table geometry.
	localparam int SLOTS_DEF     = 1024;
	localparam int SIZE_BITS_DEF = 16;

	// Command codes carried by a request word.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_t;

endpackage

>>> rtl/core/bfsa_ifs.sv
// Request channel: command, slot index and size.
interface bfsa_req_if import bfsa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [IDX_FIELD_W-1:0]  slot_index;
	logic [SIZE_FIELD_W-1:0] size_value;

	modport source(output valid, output cmd, output slot_index, output size_value,
		input ready);
	modport sink(input valid, input cmd, input slot_index, input size_value,
		output ready);
endinterface

// Grant channel: granted slot and hit flag.
interface bfsa_grant_if import bfsa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [IDX_FIELD_W-1:0] granted_slot;
	logic                   found;

	modport source(output valid, output granted_slot, output found, input ready);
	modport sink(input valid, input granted_slot, input found, output ready);
endinterface

>>> rtl/core/bfsa_slot_mem.sv
module bfsa_slot_mem import bfsa_pkg::*; #(
	parameter int SLOTS  = SLOTS_DEF,
	parameter int WORD_W = SIZE_BITS_DEF + 1,
	localparam int IDX_W = $clog2(SLOTS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [IDX_W-1:0]  raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [SLOTS];
	logic [WORD_W-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/bfsa_ctrl.sv
module bfsa_ctrl import bfsa_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF,
	localparam int IDX_W    = $clog2(SLOTS),
	localparam int WORD_W   = SIZE_BITS + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	bfsa_req_if.sink          req,
	bfsa_grant_if.source      grant,
	output logic              mem_we,
	output logic [IDX_W-1:0]  mem_waddr,
	output logic [WORD_W-1:0] mem_wdata,
	output logic [IDX_W-1:0]  mem_raddr,
	input  logic [WORD_W-1:0] mem_rdata
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REL_RD,
		ST_REL_WR,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        addr_q;
	logic                    issue_q;
	logic                    pending_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [SIZE_FIELD_W-1:0] need_q;
	logic                    have_q;
	logic [IDX_W-1:0]        best_q;
	logic [SIZE_BITS-1:0]    best_cap_q;
	logic                    ovalid_q;
	logic [IDX_FIELD_W-1:0]  oslot_q;
	logic                    ofound_q;

	logic                    accept;
	logic                    out_free;
	logic [31:0]             idx_ext;
	logic                    in_range;
	logic [IDX_W-1:0]        req_addr;
	logic [31:0]             size_ext;
	logic [SIZE_BITS-1:0]    load_cap;
	logic                    rd_free;
	logic [SIZE_BITS-1:0]    rd_cap;
	logic                    fits;
	logic                    better;
	logic                    last_rd;
	logic [31:0]             best_ext;

	// Handshakes.
	assign req.ready     = (state_q == ST_IDLE);
	assign accept        = req.valid && req.ready;
	assign out_free      = !ovalid_q || grant.ready;
	assign grant.valid        = ovalid_q;
	assign grant.granted_slot = oslot_q;
	assign grant.found        = ofound_q;

	// Decode of the incoming word.
	assign idx_ext  = 32'(req.slot_index);
	assign in_range = idx_ext < 32'(SLOTS);
	assign req_addr = idx_ext[IDX_W-1:0];
	assign size_ext = 32'(req.size_value);
	assign load_cap = size_ext[SIZE_BITS-1:0];

	// Compare of the entry read in the previous cycle against the running best.
	assign rd_free  = mem_rdata[WORD_W-1];
	assign rd_cap   = mem_rdata[SIZE_BITS-1:0];
	assign fits     = rd_free && (33'(rd_cap) >= 33'(need_q));
	assign better   = fits && (!have_q || (rd_cap < best_cap_q));
	assign last_rd  = (idx_s1 == LAST_IDX);
	assign best_ext = 32'(best_q);

	assign mem_raddr = addr_q;

	// Memory write port: clearing pass, load, release write-back, grant write-back.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept && (req.cmd == CMD_LOAD) && in_range) begin
					mem_we    = 1'b1;
					mem_waddr = req_addr;
					mem_wdata = {1'b1, load_cap};
				end
			end
			ST_REL_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, rd_cap};
			end
			ST_DONE: begin
				if (out_free && have_q) begin
					mem_we    = 1'b1;
					mem_waddr = best_q;
					mem_wdata = {1'b0, best_cap_q};
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and grant register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			issue_q    <= 1'b0;
			pending_s1 <= 1'b0;
			idx_s1     <= '0;
			need_q     <= '0;
			have_q     <= 1'b0;
			best_q     <= '0;
			best_cap_q <= '0;
			ovalid_q   <= 1'b0;
			oslot_q    <= '0;
			ofound_q   <= 1'b0;
		end else begin
			// The final state reloads the grant register itself.
			if (ovalid_q && grant.ready && (state_q != ST_DONE)) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_REQUEST) begin
							need_q     <= req.size_value;
							addr_q     <= '0;
							issue_q    <= 1'b1;
							pending_s1 <= 1'b0;
							have_q     <= 1'b0;
							best_q     <= '0;
							best_cap_q <= '0;
							state_q    <= ST_SCAN;
						end else if ((req.cmd == CMD_RELEASE) && in_range) begin
							addr_q  <= req_addr;
							state_q <= ST_REL_RD;
						end
					end
				end
				ST_REL_RD: begin
					state_q <= ST_REL_WR;
				end
				ST_REL_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					// Issue one read per cycle; the data is compared in the cycle after.
					pending_s1 <= issue_q;
					idx_s1     <= addr_q;
					if (issue_q) begin
						if (addr_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					if (pending_s1) begin
						if (better) begin
							have_q     <= 1'b1;
							best_q     <= idx_s1;
							best_cap_q <= rd_cap;
						end
						if (last_rd) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						oslot_q  <= have_q ? best_ext[IDX_FIELD_W-1:0] : '0;
						ofound_q <= have_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/best_fit_seat_allocator.sv
// Best-fit slot allocator over a table held in one synchronous memory.
// Request: one read per slot through the single read port, each entry compared against
// the running best, then the grant register; no new word is taken until that register
// is loaded. Load writes the table in the cycle it is accepted; release reads the entry,
// then writes it back free. A grant word left waiting holds the next request in ST_DONE,
// and the input stalls. Reset (arst_n low) runs a clearing pass that marks every slot taken.
module best_fit_seat_allocator import bfsa_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bfsa_req_if.sink     req,
	bfsa_grant_if.source grant
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int WORD_W = SIZE_BITS + 1;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	// Sequencer: decode, scan, read-modify-write and grant register.
	bfsa_ctrl #(
		.SLOTS     (SLOTS),
		.SIZE_BITS (SIZE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.grant     (grant),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Slot table: free bit above the capacity in each word.
	bfsa_slot_mem #(
		.SLOTS  (SLOTS),
		.WORD_W (WORD_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

>>> dv/seat_grant_checker.sv
`timescale 1ns / 100ps

// Watches the request and grant channels, predicts every grant word, and
// compares each accepted grant with the oldest prediction.
module seat_grant_checker import bfsa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	bfsa_req_if   req,
	bfsa_grant_if grant,
	output int    fail_count,
	output int    grants_due_count,
	output int    hit_count
);

	localparam int DUE_DEPTH = 16;

	typedef struct packed {
		logic [IDX_FIELD_W-1:0] slot;
		logic                   found;
	} grant_word_t;

	// Shadow copy of the seat table.
	logic [SIZE_FIELD_W-1:0] seat_cap [SLOTS_DEF];
	bit                      seat_free [SLOTS_DEF];

	// Predicted grant words in order, kept in a ring.
	grant_word_t grants_due [DUE_DEPTH];
	int          due_head;
	int          due_tail;
	grant_word_t oldest;

	// Best fit: the smallest free capacity that covers the need, lowest index on a tie.
	// The chosen seat is marked taken.
	function automatic grant_word_t allocate_seat(input logic [SIZE_FIELD_W-1:0] need);
		grant_word_t             g;
		logic [SIZE_FIELD_W-1:0] best_cap;
		g = '0;
		best_cap = '0;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			if (seat_free[i] && seat_cap[i] >= need && (!g.found || seat_cap[i] < best_cap)) begin
				g.found = 1'b1;
				g.slot = IDX_FIELD_W'(i);
				best_cap = seat_cap[i];
			end
		end
		if (g.found)
			seat_free[g.slot] = 1'b0;
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (seat_free[i])
				seat_free[i] = 1'b0;
			due_head = 0;
			due_tail = 0;
			fail_count = 0;
			grants_due_count = 0;
			hit_count = 0;
		end else begin
			// A grant word always belongs to a request accepted on an earlier edge,
			// so it is checked before this edge's request word is predicted.
			if (grant.valid && grant.ready) begin
				if (due_tail == due_head) begin
					fail_count++;
					$display("%0t: unexpected grant word, expected none, actual slot %0d found %0b",
						$time, grant.granted_slot, grant.found);
				end else begin
					oldest = grants_due[due_head % DUE_DEPTH];
					due_head++;
					if (grant.found !== oldest.found) begin
						fail_count++;
						$display("%0t: found mismatch, expected %0b, actual %0b",
							$time, oldest.found, grant.found);
					end
					if (grant.granted_slot !== oldest.slot) begin
						fail_count++;
						$display("%0t: granted_slot mismatch, expected %0d, actual %0d",
							$time, oldest.slot, grant.granted_slot);
					end
				end
				if (grant.found === 1'b1)
					hit_count++;
			end

			// Apply the accepted request word to the shadow table.
			if (req.valid && req.ready) begin
				case (req.cmd)
					CMD_LOAD: begin
						seat_cap[req.slot_index] = req.size_value;
						seat_free[req.slot_index] = 1'b1;
					end
					CMD_RELEASE: begin
						seat_free[req.slot_index] = 1'b1;
					end
					CMD_REQUEST: begin
						grants_due[due_tail % DUE_DEPTH] = allocate_seat(req.size_value);
						due_tail++;
					end
					default: ;
				endcase
			end
			grants_due_count = due_tail - due_head;
		end
	end

endmodule

>>> dv/best_fit_seat_allocator_tb.sv
`timescale 1ns / 100ps

module best_fit_seat_allocator_tb;
	import bfsa_pkg::*;

	localparam int     CLK_PERIOD   = 12;
	localparam int     RESET_CYCLES = 12;
	localparam int     DRAIN_CYCLES = SLOTS_DEF + 16;
	localparam int     HOLD_CYCLES  = 6 * (SLOTS_DEF + 3);
	localparam int     PHASE_ITEMS  = 185;
	localparam longint LIMIT_NS     = 64'd48_000_000;

	// Command code that the block ignores.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Idle percentages of sender and receiver, one pair per random phase.
	localparam int SEND_PCT [3] = '{16, 67, 0};
	localparam int RECV_PCT [3] = '{67, 16, 0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bfsa_req_if   req();
	bfsa_grant_if grant();

	int fail_count;
	int grants_due_count;
	int hit_count;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_grants;

	// Seats that have been loaded, so that a release never frees an unwritten entry.
	bit                      seat_loaded [SLOTS_DEF];
	logic [SIZE_FIELD_W-1:0] loaded_cap [SLOTS_DEF];
	int                      loaded_seats [SLOTS_DEF];
	int                      n_loaded;

	int n_load;
	int n_request;
	int n_release;
	int n_ignored;

	best_fit_seat_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.grant  (grant)
	);

	seat_grant_checker grant_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.req              (req),
		.grant            (grant),
		.fail_count       (fail_count),
		.grants_due_count (grants_due_count),
		.hit_count        (hit_count)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit.
	initial begin
		#(LIMIT_NS);
		$display("FAIL best_fit_seat_allocator");
		$finish;
	end

	// Grant receiver: random stalls, or one long hold-off counted here.
	initial begin
		grant.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_grants) begin
				grant.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_grants = 1'b0;
			end else begin
				grant.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one request word and wait until it is accepted.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_FIELD_W-1:0] slot,
		input logic [SIZE_FIELD_W-1:0] size);
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.slot_index <= slot;
		req.size_value <= size;
		do @(posedge clk); while (req.ready !== 1'b1);

		case (cmd)
			CMD_LOAD: begin
				if (!seat_loaded[slot]) begin
					loaded_seats[n_loaded] = int'(slot);
					n_loaded++;
				end
				seat_loaded[slot] = 1'b1;
				loaded_cap[slot] = size;
				n_load++;
			end
			CMD_REQUEST: n_request++;
			CMD_RELEASE: n_release++;
			default: n_ignored++;
		endcase
	endtask

	// Request sizes mostly sit at or near a loaded capacity so that fits and ties occur.
	function automatic logic [SIZE_FIELD_W-1:0] pick_need();
		logic [SIZE_FIELD_W-1:0] base;
		if (n_loaded > 0 && $urandom_range(9) < 7) begin
			base = loaded_cap[loaded_seats[$urandom_range(n_loaded - 1)]];
			case ($urandom_range(2))
				0: return base;
				1: return (base > 3) ? base - SIZE_FIELD_W'($urandom_range(3)) : '0;
				default: return (base < 16'hFFFF) ? base + 1'b1 : base;
			endcase
		end
		case ($urandom_range(9))
			0: return '0;
			1: return 16'hFFFF;
			default: return SIZE_FIELD_W'($urandom);
		endcase
	endfunction

	// One random word: loads, requests and releases, with a few ignored words.
	task automatic send_random_word();
		int                      pick;
		logic [IDX_FIELD_W-1:0]  slot;
		logic [SIZE_FIELD_W-1:0] size;
		pick = $urandom_range(99);
		if (pick < 5) begin
			slot = IDX_FIELD_W'($urandom);
			size = SIZE_FIELD_W'($urandom);
			send_word(CMD_UNUSED, slot, size);
		end else if (pick < 40 || (pick >= 75 && n_loaded == 0)) begin
			case ($urandom_range(2))
				0: slot = IDX_FIELD_W'($urandom);
				1: slot = IDX_FIELD_W'($urandom_range(15));
				default: slot = 10'h3F0 | IDX_FIELD_W'($urandom_range(15));
			endcase
			case ($urandom_range(9))
				0: size = '0;
				1: size = 16'hFFFF;
				2, 3, 4: size = SIZE_FIELD_W'($urandom_range(15) * 16);
				default: size = SIZE_FIELD_W'($urandom);
			endcase
			send_word(CMD_LOAD, slot, size);
		end else if (pick < 75) begin
			slot = IDX_FIELD_W'($urandom);
			send_word(CMD_REQUEST, slot, pick_need());
		end else begin
			slot = IDX_FIELD_W'(loaded_seats[$urandom_range(n_loaded - 1)]);
			size = SIZE_FIELD_W'($urandom);
			send_word(CMD_RELEASE, slot, size);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int target;
		req.valid <= 1'b0;
		req.cmd <= CMD_LOAD;
		req.slot_index <= '0;
		req.size_value <= '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_grants = 1'b0;
		n_loaded = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A request on an empty table misses.
		send_word(CMD_REQUEST, 10'd0, 16'd0);
		send_word(CMD_LOAD, 10'd0, 16'd0);
		send_word(CMD_LOAD, 10'd1023, 16'hFFFF);
		send_word(CMD_LOAD, 10'd5, 16'd100);
		send_word(CMD_LOAD, 10'd6, 16'd100);
		send_word(CMD_LOAD, 10'd7, 16'd50);
		// Zero need takes the zero-capacity seat; equal capacities go lowest index first.
		send_word(CMD_REQUEST, 10'd0, 16'd0);
		send_word(CMD_REQUEST, 10'd0, 16'd100);
		send_word(CMD_REQUEST, 10'd0, 16'd100);
		send_word(CMD_REQUEST, 10'd0, 16'd100);
		send_word(CMD_REQUEST, 10'd0, 16'd100);
		send_word(CMD_REQUEST, 10'd0, 16'hFFFF);
		// Release makes the largest seat available again.
		send_word(CMD_RELEASE, 10'd1023, 16'd0);
		send_word(CMD_REQUEST, 10'd0, 16'hFFFF);
		// A second release of a seat that is already free changes nothing.
		send_word(CMD_RELEASE, 10'd5, 16'hFFFF);
		send_word(CMD_RELEASE, 10'd5, 16'd0);
		send_word(CMD_REQUEST, 10'd0, 16'd60);
		// A load over a taken seat frees it with its new capacity.
		send_word(CMD_LOAD, 10'd6, 16'd60);
		send_word(CMD_REQUEST, 10'd0, 16'd55);
		send_word(CMD_RELEASE, 10'd7, 16'd0);
		send_word(CMD_REQUEST, 10'd0, 16'd1);
		// The unused command must not act as a load of the last seat.
		send_word(CMD_UNUSED, 10'd1023, 16'd0);
		send_word(CMD_REQUEST, 10'd1023, 16'd0);
		req.valid <= 1'b0;
		// The edge below lets the checker count the last accepted word before the wait.
		@(posedge clk);
		wait (grants_due_count == 0);
		@(posedge clk);

		// Random phases with different idle profiles; the sender drains between them.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = SEND_PCT[phase];
			recv_idle_pct = RECV_PCT[phase];
			target = n_load + n_request + n_release + PHASE_ITEMS;
			if (phase == 2) begin
				// Long receiver hold-off while requests keep coming, so the input stalls.
				hold_grants = 1'b1;
				repeat (4) send_word(CMD_REQUEST, IDX_FIELD_W'($urandom), pick_need());
			end
			while (n_load + n_request + n_release < target)
				send_random_word();
			req.valid <= 1'b0;
			@(posedge clk);
			wait (grants_due_count == 0);
			@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d loads, %0d requests (%0d granted), %0d releases, %0d ignored words,",
			n_load, n_request, hit_count, n_release, n_ignored);
		$display("over three idle profiles with one long grant hold-off.");
		if (fail_count == 0 && grants_due_count == 0)
			$display("PASS best_fit_seat_allocator");
		else
			$display("FAIL best_fit_seat_allocator");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/bfsa_pkg.sv
rtl/core/bfsa_ifs.sv
rtl/core/bfsa_slot_mem.sv
rtl/core/bfsa_ctrl.sv
rtl/core/best_fit_seat_allocator.sv
dv/seat_grant_checker.sv
dv/best_fit_seat_allocator_tb.sv
